FILE: rtl/escape_sequence_decoder_assert.svh
// Assertion macros used by the escape decoder result queue.
`ifndef ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ESCD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define ESCD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/escd_pkg.sv
// Types and constants of the escape sequence decoder.
package escd_pkg;

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam logic [7:0] BYTE_ADDR = 8'hFF;
    localparam logic [7:0] BYTE_LINE = 8'hFE;
    localparam logic [7:0] BYTE_TERM = 8'h00;

    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_oq_word;

    // Words produced by one accepted character, w0 first.
    typedef struct packed {
        logic [1:0] cnt;
        t_oq_word   w0;
        t_oq_word   w1;
    } t_dec_res;

endpackage

FILE: rtl/escape_sequence_decoder.sv
// Top level of the backslash escape decoder.
// One text character is taken per word on the slave side and decoded at once into zero, one or
// two bytes, which enter a four-word result queue; with the queue empty, the first byte appears
// on the master side in the cycle after the character is taken. A character is taken in any
// cycle in which the queue has room for two words, so characters that give no byte or one byte
// flow at one per cycle while the master side takes each byte, whereas those giving two bytes (an
// unknown escape, a number closed by a plain character, end of text after a number) fill the
// queue faster than the single-word output port drains it and so hold back the slave side.
module escape_sequence_decoder
    import escd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    input  logic       i_s_axis_tuser,   // [0] end_of_text
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] byte_out
    output logic       o_m_axis_tlast    // is_last
);

    logic     take;
    logic     room2;
    logic     pop;
    t_dec_res res;
    t_oq_word head;

    assign take = i_s_axis_tvalid && room2;
    assign pop  = o_m_axis_tvalid && i_m_axis_tready;

    escd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_char  (i_s_axis_tdata),
        .i_eot   (i_s_axis_tuser),
        .o_res   (res)
    );

    escd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_room2 (room2),
        .o_valid (o_m_axis_tvalid),
        .i_pop   (pop),
        .o_word  (head)
    );

    assign o_s_axis_tready = room2;
    assign o_m_axis_tdata  = head.data;
    assign o_m_axis_tlast  = head.last;

endmodule

FILE: rtl/escd_decode.sv
// Escape state registers and the per-character decode logic.
module escd_decode
    import escd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_char,
    input  logic       i_eot,
    output t_dec_res   o_res
);

    logic       r_in_esc, n_in_esc;
    logic [8:0] r_oct,    n_oct;
    logic [1:0] r_dcnt,   n_dcnt;

    logic       is_bsl;
    logic       is_digit;
    t_dec_res   res;

    assign is_bsl   = (i_char == CH_BSL);
    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_SEVEN);

    always_comb begin
        n_in_esc = r_in_esc;
        n_oct    = r_oct;
        n_dcnt   = r_dcnt;
        res.cnt  = 2'd0;
        res.w0   = '{data: BYTE_TERM, last: 1'b0};
        res.w1   = '{data: BYTE_TERM, last: 1'b0};
        if (i_eot) begin
            n_in_esc = 1'b0;
            n_oct    = 9'd0;
            n_dcnt   = 2'd0;
            // pending number goes out ahead of the terminator
            if (r_in_esc && (r_dcnt != 2'd0)) begin
                res.w0.data = r_oct[7:0];
                res.w1      = '{data: BYTE_TERM, last: 1'b1};
                res.cnt     = 2'd2;
            end else begin
                res.w0      = '{data: BYTE_TERM, last: 1'b1};
                res.cnt     = 2'd1;
            end
        end else if (!r_in_esc) begin
            if (is_bsl) begin
                n_in_esc = 1'b1;
                n_oct    = 9'd0;
                n_dcnt   = 2'd0;
            end else begin
                res.w0.data = i_char;
                res.cnt     = 2'd1;
            end
        end else if (r_dcnt != 2'd0) begin
            if (is_digit && (r_dcnt != OCT_MAX_DIGITS)) begin
                n_oct  = {r_oct[5:0], i_char[2:0]};
                n_dcnt = r_dcnt + 2'd1;
            end else begin
                // number ends; the ending character is plain text
                res.w0.data = r_oct[7:0];
                res.cnt     = 2'd1;
                n_oct       = 9'd0;
                n_dcnt      = 2'd0;
                if (is_bsl) begin
                    n_in_esc = 1'b1;
                end else begin
                    n_in_esc    = 1'b0;
                    res.w1.data = i_char;
                    res.cnt     = 2'd2;
                end
            end
        end else if (is_digit) begin
            n_oct  = {6'd0, i_char[2:0]};
            n_dcnt = 2'd1;
        end else begin
            n_in_esc = 1'b0;
            n_oct    = 9'd0;
            n_dcnt   = 2'd0;
            res.cnt  = 2'd1;
            unique case (i_char)
                CH_N:     res.w0.data = BYTE_LF;
                CH_R:     res.w0.data = BYTE_CR;
                CH_T:     res.w0.data = BYTE_TAB;
                CH_QUOTE: res.w0.data = CH_QUOTE;
                CH_BSL:   res.w0.data = CH_BSL;
                CH_I:     res.w0.data = BYTE_ADDR;
                CH_HASH:  res.w0.data = BYTE_LINE;
                default: begin
                    // unknown escape: backslash then the character
                    res.w0.data = CH_BSL;
                    res.w1.data = i_char;
                    res.cnt     = 2'd2;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_esc <= 1'b0;
            r_oct    <= 9'd0;
            r_dcnt   <= 2'd0;
        end else if (i_take) begin
            r_in_esc <= n_in_esc;
            r_oct    <= n_oct;
            r_dcnt   <= n_dcnt;
        end
    end

    always_comb begin
        o_res     = res;
        o_res.cnt = i_take ? res.cnt : 2'd0;
    end

endmodule

FILE: rtl/escd_outq.sv
// Four-word result queue: takes up to two words a cycle, gives at most one.
module escd_outq
    import escd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dec_res   i_res,
    output logic       o_room2,
    output logic       o_valid,
    input  logic       i_pop,
    output t_oq_word   o_word
);

    `include "escape_sequence_decoder_assert.svh"

    t_oq_word              r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]      r_wp, n_wp;
    logic [OQ_AW-1:0]      r_rp, n_rp;
    logic [OQ_CW-1:0]      r_count, n_count;
    logic [OQ_AW-1:0]      wp1;

    assign wp1 = r_wp + {{(OQ_AW-1){1'b0}}, 1'b1};

    always_comb begin
        n_wp    = r_wp + i_res.cnt[OQ_AW-1:0];
        n_rp    = i_pop ? (r_rp + {{(OQ_AW-1){1'b0}}, 1'b1}) : r_rp;
        n_count = r_count + {{(OQ_CW-2){1'b0}}, i_res.cnt}
                  - {{(OQ_CW-1){1'b0}}, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.cnt != 2'd0) begin
            r_mem[r_wp] <= i_res.w0;
        end
        if (i_res.cnt == 2'd2) begin
            r_mem[wp1] <= i_res.w1;
        end
    end

    assign o_room2 = (r_count <= OQ_CW'(OQ_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rp];

    `ESCD_ASSERT_IMP(a_oq_bound, 1'b1, r_count <= OQ_CW'(OQ_DEPTH), "result queue overfilled")
    `ESCD_ASSERT_NXT(a_oq_two, (i_res.cnt == 2'd2) && !i_pop,
                     r_count == $past(r_count) + 3'd2, "pair push lost")
    `ESCD_ASSERT_NXT(a_oq_pop, (i_res.cnt == 2'd0) && i_pop,
                     r_count == $past(r_count) - 3'd1, "pop miscounted")
    `ESCD_ASSERT_NXT(a_oq_hold, (i_res.cnt == 2'd0) && !i_pop,
                     $stable(r_count) && $stable(r_rp), "queue moved when idle")

endmodule

FILE: dv/escape_sequence_decoder_tb.sv
// Self-checking bench for the escape decoder: directed and random text against a byte predictor.
module escape_sequence_decoder_tb
    import escd_pkg::*;
();

    localparam int TEXT_ITEMS  = 1850;
    localparam int PHASES      = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SRC_IDLE,
        FLOW_SINK_STALL,
        FLOW_BOTH
    } t_flow;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } t_text_item;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tuser   = 1'b0;
    logic       m_tready  = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tlast;

    t_text_item text_q[$];
    t_oq_word   byte_q[$];
    t_flow      flow = FLOW_FREE;

    // decoder state as predicted
    logic       in_esc     = 1'b0;
    logic [8:0] oct_acc    = 9'd0;
    logic [1:0] oct_digits = 2'd0;

    logic       char_taken  = 1'b0;
    int         idle_cycles = 0;
    int         err_count   = 0;
    int         items_queued = 0;
    int         chars_in    = 0;
    int         bytes_out   = 0;
    int         strings_ended = 0;
    t_oq_word   want;
    t_text_item nxt;

    escape_sequence_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("MISMATCH %s: got %0h, expected %0h (byte %0d)", what, got, exp_val, bytes_out);
        err_count++;
    endtask

    task automatic emit(input logic [7:0] b, input logic last);
        t_oq_word w;
        w.data = b;
        w.last = last;
        byte_q.push_back(w);
    endtask

    task automatic clear_escape();
        in_esc     = 1'b0;
        oct_acc    = 9'd0;
        oct_digits = 2'd0;
    endtask

    task automatic plain_byte(input logic [7:0] ch);
        if (ch == CH_BSL) begin
            clear_escape();
            in_esc = 1'b1;
        end else begin
            emit(ch, 1'b0);
        end
    endtask

    task automatic decode_char(input logic [7:0] ch, input logic eot);
        logic is_oct;
        is_oct = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
        if (eot) begin
            if (in_esc && oct_digits != 2'd0)
                emit(oct_acc[7:0], 1'b0);
            emit(BYTE_TERM, 1'b1);
            clear_escape();
        end else if (!in_esc) begin
            plain_byte(ch);
        end else if (oct_digits != 2'd0) begin
            if (is_oct && oct_digits < OCT_MAX_DIGITS) begin
                oct_acc    = {oct_acc[5:0], ch[2:0]};
                oct_digits = oct_digits + 2'd1;
            end else begin
                // number closed: emit it, then treat the char as plain text
                emit(oct_acc[7:0], 1'b0);
                clear_escape();
                plain_byte(ch);
            end
        end else if (is_oct) begin
            oct_acc    = {6'd0, ch[2:0]};
            oct_digits = 2'd1;
        end else begin
            clear_escape();
            case (ch)
                CH_N:     emit(BYTE_LF, 1'b0);
                CH_R:     emit(BYTE_CR, 1'b0);
                CH_T:     emit(BYTE_TAB, 1'b0);
                CH_QUOTE: emit(CH_QUOTE, 1'b0);
                CH_BSL:   emit(CH_BSL, 1'b0);
                CH_I:     emit(BYTE_ADDR, 1'b0);
                CH_HASH:  emit(BYTE_LINE, 1'b0);
                default: begin
                    emit(CH_BSL, 1'b0);
                    emit(ch, 1'b0);
                end
            endcase
        end
    endtask

    task automatic push_char(input logic [7:0] ch, input logic eot);
        t_text_item it;
        it.ch  = ch;
        it.eot = eot;
        text_q.push_back(it);
        items_queued++;
    endtask

    task automatic push_str(input string s);
        for (int k = 0; k < s.len(); k++)
            push_char(s[k], 1'b0);
    endtask

    task automatic push_octal(input int n_digits);
        push_char(CH_BSL, 1'b0);
        for (int k = 0; k < n_digits; k++)
            push_char(CH_ZERO + 8'($urandom_range(7)), 1'b0);
    endtask

    // Mostly well-formed escapes with random content, plus some noise.
    task automatic gen_random_text(input int goal);
        logic [7:0] c;
        int         pick;
        logic [7:0] known [7];
        known = '{CH_N, CH_R, CH_T, CH_QUOTE, CH_BSL, CH_I, CH_HASH};
        while (items_queued < goal) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                c = 8'($urandom);
                while (c == CH_BSL)
                    c = 8'($urandom);
                push_char(c, 1'b0);
            end else if (pick < 50) begin
                push_char(CH_BSL, 1'b0);
                push_char(known[$urandom_range(6)], 1'b0);
            end else if (pick < 70) begin
                push_octal($urandom_range(1, 3));
            end else if (pick < 78) begin
                push_char(CH_BSL, 1'b0);
                push_char(8'($urandom), 1'b0);
            end else if (pick < 85) begin
                // backslash and up to three octal digits, then 8, 9 or another octal digit
                push_octal($urandom_range(0, 3));
                if ($urandom_range(1) == 0)
                    push_char(CH_SEVEN + 8'd1 + 8'($urandom_range(1)), 1'b0);
                else
                    push_char(CH_ZERO + 8'($urandom_range(7)), 1'b0);
            end else if (pick < 92) begin
                push_char(8'($urandom), 1'b1);
            end else begin
                push_char(8'($urandom), ($urandom_range(7) == 0));
            end
        end
    endtask

    function automatic logic src_idles();
        case (flow)
            FLOW_SRC_IDLE: return $urandom_range(99) < 75;
            FLOW_BOTH:     return $urandom_range(99) < 24;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic logic sink_stalls();
        case (flow)
            FLOW_SINK_STALL: return $urandom_range(99) < 75;
            FLOW_BOTH:       return $urandom_range(99) < 24;
            default:         return 1'b0;
        endcase
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_tvalid || char_taken) begin
                if (text_q.size() != 0 && !src_idles()) begin
                    nxt = text_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.ch;
                    s_tuser  <= nxt.eot;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !sink_stalls();
        end
    end

    // monitor: predict on each accepted char, check each accepted byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_taken  <= 1'b0;
            idle_cycles <= 0;
        end else begin
            char_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                decode_char(s_tdata, s_tuser);
                chars_in++;
                if (s_tuser)
                    strings_ended++;
            end
            if (m_tvalid && m_tready) begin
                if (byte_q.size() == 0) begin
                    report_mismatch("word with nothing expected", int'(m_tdata), 0);
                end else begin
                    want = byte_q.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch("byte_out", int'(m_tdata), int'(want.data));
                    if (m_tlast !== want.last)
                        report_mismatch("is_last", int'(m_tlast), int'(want.last));
                end
                bytes_out++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int goal;
        goal = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero and 0xFF as text, every known escape, the octal corner cases,
        // a dangling backslash at end and a number flushed by end of text
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b0);
        push_str("\\r\\t\\\"\\\\\\i\\#");
        push_str("\\3\\n\\9\\7777\\1t\\28\\");
        push_char(8'h00, 1'b1);
        push_str("\\5");
        push_char(8'hFF, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            flow = t_flow'(p);
            goal += TEXT_ITEMS / PHASES;
            gen_random_text(goal);
            push_char(8'($urandom), 1'b1);
            while (text_q.size() != 0 || s_tvalid)
                @(posedge i_clk);
        end

        while (byte_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Decoded %0d chars into %0d bytes over %0d strings, four flow-control phases.",
                 chars_in, bytes_out, strings_ended);
        $display("Mismatches found: %0d", err_count);
        if (err_count == 0 && byte_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
